@@ design/u8d_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u8d_pkg
// Shared types and constants of the six-byte UTF-8 sequence decoder.
// ============================================================================
package u8d_pkg;

    typedef logic [1:0] u8d_status_t;

    localparam u8d_status_t ST_VALID      = 2'd0;
    localparam u8d_status_t ST_INCOMPLETE = 2'd1;
    localparam u8d_status_t ST_INVALID    = 2'd2;

    localparam logic [2:0] AVAIL_MAX = 3'd6;

    localparam logic [7:0] LEAD_TWO_MIN  = 8'hC2;
    localparam logic [7:0] LEAD_TWO_MAX  = 8'hDF;
    localparam logic [7:0] LEAD_THREE_MAX = 8'hEF;
    localparam logic [7:0] LEAD_FOUR_MAX = 8'hF7;
    localparam logic [7:0] LEAD_FIVE_MAX = 8'hFB;
    localparam logic [7:0] LEAD_SIX_MAX  = 8'hFD;

    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [30:0] LEAST_TWO   = 31'h0000080;
    localparam logic [30:0] LEAST_THREE = 31'h0000800;
    localparam logic [30:0] LEAST_FOUR  = 31'h0010000;
    localparam logic [30:0] LEAST_FIVE  = 31'h0200000;
    localparam logic [30:0] LEAST_SIX   = 31'h4000000;

    localparam logic [30:0] SURR_LOW  = 31'h000D800;
    localparam logic [30:0] SURR_HIGH = 31'h000DFFF;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic [7:0] fifth_byte;
        logic [7:0] sixth_byte;
        logic [2:0] bytes_available;
    } u8d_in_t;

    typedef struct packed {
        logic [30:0] code_point;
        u8d_status_t status;
        logic [2:0]  consumed;
    } u8d_out_t;

    typedef struct packed {
        logic        early;
        u8d_status_t early_status;
        logic [6:0]  early_cp;
        logic [2:0]  early_len;
        logic [2:0]  len;
        logic [4:0]  lead_bits;
        logic [2:0]  avail;
        logic [4:0]  cont_ok;
        logic [4:0][5:0] cont_bits;
    } u8d_cls_t;

    typedef struct packed {
        logic        decided;
        u8d_status_t status;
        logic [30:0] code_point;
        logic [2:0]  len;
    } u8d_asm_t;

endpackage

@@ design/u8d_classify.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u8d_classify
// First stage: decodes the lead byte, saturates the byte count and tags the
// continuation bytes.
// ============================================================================
module u8d_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8d_pkg::u8d_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output u8d_pkg::u8d_cls_t out_data
);
    import u8d_pkg::*;

    logic           valid_reg;
    u8d_cls_t       data_reg;
    u8d_cls_t       data_next;
    logic [4:0][7:0] tail;
    logic [7:0]     lead;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        tail = {in_data.sixth_byte, in_data.fifth_byte, in_data.fourth_byte,
                in_data.third_byte, in_data.second_byte};
        lead = in_data.first_byte;
        data_next = '0;
        data_next.early_status = ST_VALID;
        data_next.avail = (in_data.bytes_available > AVAIL_MAX) ? AVAIL_MAX
                                                                : in_data.bytes_available;
        for (int i = 0; i < 5; i++) begin
            data_next.cont_ok[i]   = (tail[i][7:6] == CONT_TAG);
            data_next.cont_bits[i] = tail[i][5:0];
        end
        if (data_next.avail == 3'd0) begin
            data_next.early        = 1'b1;
            data_next.early_status = ST_INCOMPLETE;
        end else if (!lead[7]) begin
            data_next.early     = 1'b1;
            data_next.early_cp  = lead[6:0];
            data_next.early_len = (lead == 8'd0) ? 3'd0 : 3'd1;
        end else if (lead < LEAD_TWO_MIN || lead > LEAD_SIX_MAX) begin
            data_next.early        = 1'b1;
            data_next.early_status = ST_INVALID;
        end else if (lead <= LEAD_TWO_MAX) begin
            data_next.len       = 3'd2;
            data_next.lead_bits = lead[4:0];
        end else if (lead <= LEAD_THREE_MAX) begin
            data_next.len       = 3'd3;
            data_next.lead_bits = {1'b0, lead[3:0]};
        end else if (lead <= LEAD_FOUR_MAX) begin
            data_next.len       = 3'd4;
            data_next.lead_bits = {2'b0, lead[2:0]};
        end else if (lead <= LEAD_FIVE_MAX) begin
            data_next.len       = 3'd5;
            data_next.lead_bits = {3'b0, lead[1:0]};
        end else begin
            data_next.len       = 3'd6;
            data_next.lead_bits = {4'b0, lead[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/u8d_assemble.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u8d_assemble
// Second stage: checks the continuation positions in order and assembles
// the code point from the payload bits.
// ============================================================================
module u8d_assemble (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8d_pkg::u8d_cls_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output u8d_pkg::u8d_asm_t out_data
);
    import u8d_pkg::*;

    logic            valid_reg;
    u8d_asm_t        data_reg;
    u8d_asm_t        data_next;
    logic            hit;
    u8d_status_t     fail_status;
    logic [30:0]     acc;
    logic [4:0][5:0] c;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        c           = in_data.cont_bits;
        hit         = 1'b0;
        fail_status = ST_INVALID;
        for (int k = 1; k < 6; k++) begin
            if (!hit && 3'(k) < in_data.len) begin
                if (3'(k) >= in_data.avail) begin
                    hit         = 1'b1;
                    fail_status = ST_INCOMPLETE;
                end else if (!in_data.cont_ok[k-1]) begin
                    hit         = 1'b1;
                    fail_status = ST_INVALID;
                end
            end
        end

        case (in_data.len)
            3'd2:    acc = 31'({in_data.lead_bits, c[0]});
            3'd3:    acc = 31'({in_data.lead_bits[3:0], c[0], c[1]});
            3'd4:    acc = 31'({in_data.lead_bits[2:0], c[0], c[1], c[2]});
            3'd5:    acc = 31'({in_data.lead_bits[1:0], c[0], c[1], c[2], c[3]});
            3'd6:    acc = {in_data.lead_bits[0], c[0], c[1], c[2], c[3], c[4]};
            default: acc = '0;
        endcase

        data_next = '0;
        if (in_data.early) begin
            data_next.decided    = 1'b1;
            data_next.status     = in_data.early_status;
            data_next.code_point = 31'(in_data.early_cp);
            data_next.len        = in_data.early_len;
        end else if (hit) begin
            data_next.decided = 1'b1;
            data_next.status  = fail_status;
        end else begin
            data_next.status     = ST_VALID;
            data_next.code_point = acc;
            data_next.len        = in_data.len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/u8d_range.sv @@
`timescale 1ns / 1ps
// ============================================================================
// u8d_range
// Third stage: rejects overlong forms and surrogates and holds the result
// transaction in the output register.
// ============================================================================
module u8d_range (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8d_pkg::u8d_asm_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output u8d_pkg::u8d_out_t out_data
);
    import u8d_pkg::*;

    logic        valid_reg;
    u8d_out_t    data_reg;
    u8d_out_t    data_next;
    logic [30:0] least;
    logic        bad_range;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        case (in_data.len)
            3'd2:    least = LEAST_TWO;
            3'd3:    least = LEAST_THREE;
            3'd4:    least = LEAST_FOUR;
            3'd5:    least = LEAST_FIVE;
            3'd6:    least = LEAST_SIX;
            default: least = '0;
        endcase
        bad_range = (in_data.code_point < least) ||
                    (in_data.code_point >= SURR_LOW && in_data.code_point <= SURR_HIGH);

        data_next = '0;
        if (in_data.decided) begin
            data_next.code_point = in_data.code_point;
            data_next.status     = in_data.status;
            data_next.consumed   = in_data.len;
        end else if (bad_range) begin
            data_next.status = ST_INVALID;
        end else begin
            data_next.code_point = in_data.code_point;
            data_next.status     = ST_VALID;
            data_next.consumed   = in_data.len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ design/utf8_sequence_decoder.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8_sequence_decoder
// Decodes the first character of a six-byte window, legacy five- and
// six-byte forms included, as a three-stage pipeline.
// ============================================================================
//  Channel   Direction  Handshake           Payload
//  s_        in         s_valid / s_ready   u8d_in_t  (six bytes, byte count)
//  m_        out        m_valid / m_ready   u8d_out_t (code point, status, length)
//
// Each window passes through three register stages: lead classification,
// continuation check with assembly, and range check into the output register.
// One transaction is accepted every cycle while no stall from m_ready holds the pipeline back.
// Reset clears the valid bit of each stage; payload registers are not reset.
// A stalled stage holds its contents and only stages with room take new data.
// ============================================================================
module utf8_sequence_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  u8d_pkg::u8d_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output u8d_pkg::u8d_out_t m_payload
);
    import u8d_pkg::*;

    logic     cls_valid;
    logic     cls_ready;
    u8d_cls_t cls_data;
    logic     asm_valid;
    logic     asm_ready;
    u8d_asm_t asm_data;

    u8d_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_data  (cls_data)
    );

    u8d_assemble u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (asm_valid),
        .out_ready (asm_ready),
        .out_data  (asm_data)
    );

    u8d_range u_range (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (asm_valid),
        .in_ready  (asm_ready),
        .in_data   (asm_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_payload)
    );

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status != ST_VALID) |->
        (m_payload.code_point == '0 && m_payload.consumed == 3'd0))
        else $error("Failed decode carries a nonzero code point or length.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status == ST_VALID || m_payload.status == ST_INCOMPLETE ||
                     m_payload.status == ST_INVALID))
        else $error("Result status is not a defined code.");

    a_no_surrogate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == ST_VALID) |->
        !(m_payload.code_point >= SURR_LOW && m_payload.code_point <= SURR_HIGH))
        else $error("Surrogate code point reported as valid.");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("Pipeline stalls although the result side is ready.");

endmodule
